>>> hdl/euclidean_cluster_extraction_top_macros.svh
// Assertion macros for the cluster extraction block.
// Taken in by the top level; depends on nothing else.
`ifndef EUCLIDEAN_CLUSTER_EXTRACTION_TOP_MACROS_SVH
`define EUCLIDEAN_CLUSTER_EXTRACTION_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define ECX_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ECX_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ECX_ASSERT(lbl, prop, msg)
`define ECX_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> hdl/ecx_pkg.sv
// Shared constants for the cluster extraction block.
// No dependencies.
package ecx_pkg;
	localparam int MAX_POINTS_DEF = 32;
	localparam int COORD_BITS_DEF = 16;
	localparam int RADIUS_W = 36;
	localparam int SIZE_W = 6;
	localparam int IDX_OUT_W = 5;
	localparam int TOTAL_W = 6;
	localparam int DATA_W = 64;
	localparam int ADDR_W = 5;
	localparam logic [1:0] REG_RADIUS = 2'd0;
	localparam logic [1:0] REG_MIN_SIZE = 2'd1;
	localparam logic [1:0] REG_MAX_SIZE = 2'd2;
	localparam logic [SIZE_W-1:0] MIN_SIZE_RST = 6'd1;
	localparam logic [SIZE_W-1:0] MAX_SIZE_RST = 6'd32;
endpackage

>>> hdl/euclidean_cluster_extraction_top.sv
// Top level of the cluster extraction block: control sequencer, config registers.
// Depends on ecx_pkg, ecx_ram, ecx_dist and the assertion macro header.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  input    | start & !busy         | kind, x_coord, y_coord, z_coord
//  result   | strobe (one cycle)    | point_index, cluster_number, last_in_cluster,
//           |                       | end_of_run, overflow_seen, cluster_total
//  config   | psel&penable&pwrite   | paddr, pwdata (prdata on reads)
//
// During a load item busy stays low. In a run, each candidate not yet visited
// costs a store read, a registered square and a compare; each seed adds a
// queue read, a store read and a load.
// Reset clears counters, flags and registers; memories hold no reset state.
// Results are not flow controlled: the receiver takes each one as it appears.
`include "euclidean_cluster_extraction_top_macros.svh"
module euclidean_cluster_extraction_top #(
	parameter int MAX_POINTS = ecx_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = ecx_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              kind,
	input  logic signed [COORD_BITS-1:0]      x_coord,
	input  logic signed [COORD_BITS-1:0]      y_coord,
	input  logic signed [COORD_BITS-1:0]      z_coord,
	output logic                              strobe,
	output logic [ecx_pkg::IDX_OUT_W-1:0]     point_index,
	output logic [ecx_pkg::IDX_OUT_W-1:0]     cluster_number,
	output logic                              last_in_cluster,
	output logic                              end_of_run,
	output logic                              overflow_seen,
	output logic [ecx_pkg::TOTAL_W-1:0]       cluster_total,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ecx_pkg::ADDR_W-1:0]        paddr,
	input  logic [ecx_pkg::DATA_W-1:0]        pwdata,
	output logic [ecx_pkg::DATA_W-1:0]        prdata,
	output logic                              pready
);
	localparam int IDXW = $clog2(MAX_POINTS);
	localparam int CNTW = $clog2(MAX_POINTS + 1);
	localparam int PW = 3 * COORD_BITS;
	localparam logic [CNTW-1:0] CAP = CNTW'(MAX_POINTS);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_OUTER = 4'd1;
	localparam logic [3:0] ST_SEED_RD = 4'd2;
	localparam logic [3:0] ST_SEED_WAIT = 4'd3;
	localparam logic [3:0] ST_SEED_LD = 4'd4;
	localparam logic [3:0] ST_SCAN = 4'd5;
	localparam logic [3:0] ST_MUL = 4'd6;
	localparam logic [3:0] ST_CMP = 4'd7;
	localparam logic [3:0] ST_CHECK = 4'd8;
	localparam logic [3:0] ST_EMIT_RD = 4'd9;
	localparam logic [3:0] ST_EMIT_OUT = 4'd10;
	localparam logic [3:0] ST_END = 4'd11;

	logic [3:0] state_q;
	logic [CNTW-1:0] count_q, i_q, j_q, head_q, tail_q;
	logic [ecx_pkg::TOTAL_W-1:0] clusters_q;
	logic ovf_q;
	logic [MAX_POINTS-1:0] vis_q;
	logic [PW-1:0] seed_q;
	logic [ecx_pkg::RADIUS_W-1:0] radius_q;
	logic [ecx_pkg::SIZE_W-1:0] min_q, max_q;

	logic st_we, q_we, near, vis_rd, last;
	logic [IDXW-1:0] st_waddr, st_raddr, q_waddr, vis_idx;
	logic [PW-1:0] st_rdata;
	logic [IDXW-1:0] q_wdata, q_rdata;
	logic cfg_wr;

	// Config port: 64-bit registers at 8-byte spacing.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	always_comb begin
		unique case (paddr[4:3])
			ecx_pkg::REG_RADIUS:   prdata = ecx_pkg::DATA_W'(radius_q);
			ecx_pkg::REG_MIN_SIZE: prdata = ecx_pkg::DATA_W'(min_q);
			ecx_pkg::REG_MAX_SIZE: prdata = ecx_pkg::DATA_W'(max_q);
			default:               prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
			min_q <= ecx_pkg::MIN_SIZE_RST;
			max_q <= ecx_pkg::MAX_SIZE_RST;
		end else if (cfg_wr) begin
			unique case (paddr[4:3])
				ecx_pkg::REG_RADIUS:   radius_q <= pwdata[ecx_pkg::RADIUS_W-1:0];
				ecx_pkg::REG_MIN_SIZE: min_q <= pwdata[ecx_pkg::SIZE_W-1:0];
				ecx_pkg::REG_MAX_SIZE: max_q <= pwdata[ecx_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Point store: appended at load, read by the seed fetch and the candidate scan.
	assign st_we = (state_q == ST_IDLE) && start && !kind && (count_q < CAP);
	assign st_waddr = count_q[IDXW-1:0];
	assign st_raddr = (state_q == ST_SEED_WAIT) ? q_rdata : j_q[IDXW-1:0];

	ecx_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_store (
		.clk(clk), .we(st_we), .waddr(st_waddr),
		.wdata({x_coord, y_coord, z_coord}),
		.raddr(st_raddr), .rdata(st_rdata)
	);

	// Seed queue: the cluster being grown, in breadth-first order.
	assign q_we = ((state_q == ST_OUTER) && (i_q != count_q) && !vis_rd)
		|| ((state_q == ST_CMP) && near && (tail_q < CAP));
	assign q_waddr = (state_q == ST_OUTER) ? '0 : tail_q[IDXW-1:0];
	assign q_wdata = (state_q == ST_OUTER) ? i_q[IDXW-1:0] : j_q[IDXW-1:0];

	ecx_ram #(.WIDTH(IDXW), .DEPTH(MAX_POINTS)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.raddr(head_q[IDXW-1:0]), .rdata(q_rdata)
	);

	ecx_dist #(.COORD_BITS(COORD_BITS)) u_dist (
		.clk(clk), .en(state_q == ST_MUL), .seed(seed_q), .cand(st_rdata),
		.radius_sq(radius_q), .near(near)
	);

	// One visited-mark lookup: the outer index or the scan index.
	assign vis_idx = (state_q == ST_OUTER) ? i_q[IDXW-1:0] : j_q[IDXW-1:0];
	assign vis_rd = vis_q[vis_idx];
	assign last = (head_q + CNTW'(1)) == tail_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			i_q <= '0;
			j_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			clusters_q <= '0;
			ovf_q <= 1'b0;
			vis_q <= '0;
			seed_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (kind) begin
							// open a run: clear marks and cluster count
							vis_q <= '0;
							i_q <= '0;
							clusters_q <= '0;
							state_q <= ST_OUTER;
						end else if (count_q < CAP) begin
							count_q <= count_q + CNTW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				ST_OUTER: begin
					if (i_q == count_q) begin
						state_q <= ST_END;
					end else if (vis_rd) begin
						i_q <= i_q + CNTW'(1);
					end else begin
						// new cluster seeded by point i
						vis_q[vis_idx] <= 1'b1;
						head_q <= '0;
						tail_q <= CNTW'(1);
						state_q <= ST_SEED_RD;
					end
				end
				ST_SEED_RD: begin
					state_q <= (head_q == tail_q) ? ST_CHECK : ST_SEED_WAIT;
				end
				ST_SEED_WAIT: state_q <= ST_SEED_LD;
				ST_SEED_LD: begin
					seed_q <= st_rdata;
					j_q <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (j_q == count_q) begin
						head_q <= head_q + CNTW'(1);
						state_q <= ST_SEED_RD;
					end else if (vis_rd) begin
						j_q <= j_q + CNTW'(1);
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_CMP;
				ST_CMP: begin
					if (near && (tail_q < CAP)) begin
						vis_q[vis_idx] <= 1'b1;
						tail_q <= tail_q + CNTW'(1);
					end
					j_q <= j_q + CNTW'(1);
					state_q <= ST_SCAN;
				end
				ST_CHECK: begin
					if ((ecx_pkg::SIZE_W'(tail_q) >= min_q)
						&& (ecx_pkg::SIZE_W'(tail_q) <= max_q)) begin
						head_q <= '0;
						state_q <= ST_EMIT_RD;
					end else begin
						i_q <= i_q + CNTW'(1);
						state_q <= ST_OUTER;
					end
				end
				ST_EMIT_RD: begin
					if (head_q == tail_q) begin
						clusters_q <= clusters_q + ecx_pkg::TOTAL_W'(1);
						i_q <= i_q + CNTW'(1);
						state_q <= ST_OUTER;
					end else begin
						state_q <= ST_EMIT_OUT;
					end
				end
				ST_EMIT_OUT: begin
					head_q <= head_q + CNTW'(1);
					state_q <= ST_EMIT_RD;
				end
				ST_END: begin
					// drop the store contents and the overflow flag
					count_q <= '0;
					ovf_q <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign strobe = (state_q == ST_EMIT_OUT) || (state_q == ST_END);
	assign end_of_run = (state_q == ST_END);
	assign point_index = (state_q == ST_EMIT_OUT) ? ecx_pkg::IDX_OUT_W'(q_rdata) : '0;
	assign cluster_number = (state_q == ST_EMIT_OUT) ?
		clusters_q[ecx_pkg::IDX_OUT_W-1:0] : '0;
	assign last_in_cluster = (state_q == ST_EMIT_OUT) && last;
	assign overflow_seen = (state_q == ST_END) && ovf_q;
	assign cluster_total = (state_q == ST_END) ? clusters_q : '0;

	`ECX_ASSERT(a_strobe_busy, strobe |-> busy, "result strobe outside a run")
	`ECX_ASSERT(a_end_idle, end_of_run |=> !busy, "block still busy after end item")
	`ECX_ASSERT(a_count_cap, count_q <= CAP, "point count beyond capacity")
	`ECX_ASSERT(a_tail_cap, tail_q <= CAP, "seed queue beyond capacity")
	`ECX_ASSERT_ALWAYS(a_rst_idle, !arst_n |=> !busy, "block busy right after reset")
endmodule

>>> hdl/ecx_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ecx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> hdl/ecx_dist.sv
// Squared distance unit: registered per-axis squares, then sum and compare.
// Depends on ecx_pkg.
module ecx_dist #(
	parameter int COORD_BITS = ecx_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [3*COORD_BITS-1:0]       seed,
	input  logic [3*COORD_BITS-1:0]       cand,
	input  logic [ecx_pkg::RADIUS_W-1:0]  radius_sq,
	output logic                          near
);
	localparam int DW = COORD_BITS + 1;
	localparam int QW = 2 * COORD_BITS + 1;
	localparam int SW = QW + 2;
	localparam int CW = (SW > ecx_pkg::RADIUS_W) ? SW : ecx_pkg::RADIUS_W;

	logic [QW-1:0] sq_s1 [3];
	logic [SW-1:0] sum;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				logic signed [DW-1:0]   d;
				logic signed [2*DW-1:0] p;
				d = $signed({seed[k*COORD_BITS+COORD_BITS-1], seed[k*COORD_BITS +: COORD_BITS]})
					- $signed({cand[k*COORD_BITS+COORD_BITS-1], cand[k*COORD_BITS +: COORD_BITS]});
				p = d * d;
				sq_s1[k] <= p[QW-1:0];
			end
		end
	end

	assign sum = SW'(sq_s1[0]) + SW'(sq_s1[1]) + SW'(sq_s1[2]);
	assign near = CW'(sum) < CW'(radius_sq);
endmodule
